// ----- hdl/bipr_pkg.sv -----
// Package for the 3x3 boundary extraction block: shared types and constants.
// Has no dependencies; every other file of the block but bipr_if imports it.
`default_nettype none

package bipr_pkg;

    localparam int PIX_W      = 8;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [PIX_W-1:0]   PIX_WHITE    = 8'hFF;
    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [8:0]         WINDOW_ALL   = 9'h1FF;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    // control bits of the item in the window stage
    typedef struct packed
    {
        logic wr;      // pixel taken into the frame, line memory is updated
        logic emit;    // item produces an output pixel
        logic border;  // output position lies on the frame border
        logic last;    // output is the final pixel of the frame
    } bipr_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/bipr_if.sv -----
// Stream interfaces of the boundary extraction block: input and output channels.
// No dependencies.
`default_nettype none

interface bipr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] pixel_in;

    modport source (output valid, output action, output pixel_in, input ready);
    modport sink (input valid, input action, input pixel_in, output ready);
endinterface

interface bipr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/binary_interior_point_removal_3x3_top.sv -----
// 3x3 boundary extraction top: APB registers, position stage, line memory, window stage.
// Depends on bipr_pkg, bipr_if, bipr_cfg, bipr_ctrl, bipr_line_mem, bipr_window.
//
// Accepts one item (pixel or flush) every clock cycle unless a held output stalls the window
// stage. An emitting item passes through the window stage register and then the output register;
// the rate is set by the read-modify-write of the line memory (MAX_WIDTH x 16 bits, one read
// and one write port), whose same-column hazard is covered by forwarding. Output pixels
// trail the input by one row plus one pixel; after the last pixel of a frame, width + 1
// flush items push out the tail, and the final output carries frame_last. No clearing pass
// is needed after reset.
// Write image_width and image_height between frames.
`default_nettype none

module binary_interior_point_removal_3x3_top
    import bipr_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    bipr_in_if.sink                    item_in,
    bipr_out_if.source                 item_out
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [IMG_W_W-1:0] image_width;
    logic [IMG_H_W-1:0] image_height;
    logic               accept, in_ready;
    logic [AW-1:0]      rd_addr, s1_addr;
    logic               s1_valid, s1_fire, out_free;
    bipr_ctl_t          s1_ctl;
    logic [PIX_W-1:0]   s1_pixel, top, mid;
    logic               out_valid, out_last;
    logic [PIX_W-1:0]   out_pixel;

    bipr_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .image_width  (image_width),
        .image_height (image_height)
    );

    bipr_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width),
        .image_height (image_height),
        .in_valid     (item_in.valid),
        .in_action    (item_in.action),
        .in_pixel     (item_in.pixel_in),
        .in_ready     (in_ready),
        .s1_fire      (s1_fire),
        .accept       (accept),
        .rd_addr      (rd_addr),
        .s1_valid     (s1_valid),
        .s1_ctl       (s1_ctl),
        .s1_addr      (s1_addr),
        .s1_pixel     (s1_pixel)
    );

    bipr_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .wr_en    (s1_fire && s1_ctl.wr),
        .wr_addr  (s1_addr),
        .wr_pixel (s1_pixel),
        .top      (top),
        .mid      (mid)
    );

    bipr_window u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .s1_pixel  (s1_pixel),
        .top       (top),
        .mid       (mid),
        .s1_fire   (s1_fire),
        .out_free  (out_free),
        .out_ready (item_out.ready),
        .out_valid (out_valid),
        .out_pixel (out_pixel),
        .out_last  (out_last)
    );

    assign item_in.ready       = in_ready;
    assign item_out.valid      = out_valid;
    assign item_out.pixel_out  = out_pixel;
    assign item_out.frame_last = out_last;

`ifndef NO_ASSERTIONS
    // a window item that must emit holds while the output side is full
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && s1_ctl.emit && !out_free |=> s1_valid)
        else $error("window stage item dropped while output stalled");

    // every input transfer lands in the window stage
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid)
        else $error("accepted item missing from window stage");

    // output register loads only from an emitting window item
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_fire && s1_ctl.emit))
        else $error("output valid without emitting window item");

    // line memory writes only for pixels taken into the frame
    a_wr_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_ctl.wr |-> s1_valid && !(s1_ctl.emit && s1_ctl.last && !s1_ctl.border))
        else $error("line memory write on non-pixel item");
`endif

endmodule

`default_nettype wire

// ----- hdl/bipr_cfg.sv -----
// APB register file holding the frame width and height.
// Depends on bipr_pkg.
`default_nettype none

module bipr_cfg
    import bipr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [IMG_W_W-1:0]    image_width,
    output logic      [IMG_H_W-1:0]    image_height
);

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[IMG_H_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign image_width  = width_reg;
    assign image_height = height_reg;

endmodule

`default_nettype wire

// ----- hdl/bipr_ctrl.sv -----
// Position tracking stage: input and output counters, emit decision, window stage register.
// Depends on bipr_pkg.
`default_nettype none

module bipr_ctrl
    import bipr_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [IMG_W_W-1:0]           image_width,
    input  wire logic [IMG_H_W-1:0]           image_height,
    input  wire logic                         in_valid,
    input  wire logic                         in_action,
    input  wire logic [PIX_W-1:0]             in_pixel,
    output logic                              in_ready,
    input  wire logic                         s1_fire,
    output logic                              accept,
    output logic      [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic                              s1_valid,
    output bipr_ctl_t                         s1_ctl,
    output logic      [$clog2(MAX_WIDTH)-1:0] s1_addr,
    output logic      [PIX_W-1:0]             s1_pixel
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (AW + 2 > 12) ? AW + 2 : 12;

    logic [AW-1:0]      in_col_reg, in_col_next;
    logic [IMG_H_W-1:0] in_row_reg, in_row_next;
    logic [AW-1:0]      out_col_reg, out_col_next;
    logic [IMG_H_W-1:0] out_row_reg, out_row_next;
    logic               s1_valid_reg;
    bipr_ctl_t          s1_ctl_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [PIX_W-1:0]   s1_pixel_reg;

    logic [CW-1:0]      w_eff, width_ext, j_ext, j_inc, c_inc;
    logic [IMG_H_W-1:0] h_eff, row_base;
    logic [IMG_H_W:0]   r_inc;
    logic               inputs_done, do_pix, do_flush, pos_ok, emit;
    logic               col_wrap, r_last, c_last, restart, border;

    assign width_ext = CW'(image_width);
    always_comb
    begin
        if (image_width == '0)
            w_eff = CW'(1);
        else if (width_ext > CW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = width_ext;
    end
    assign h_eff = (image_height == '0) ? IMG_H_W'(1) : image_height;

    assign inputs_done = in_row_reg >= h_eff;
    assign do_pix      = !in_action && !inputs_done;
    assign do_flush    = in_action && inputs_done;

    assign j_ext    = CW'(in_col_reg);
    assign j_inc    = j_ext + CW'(1);
    assign col_wrap = j_inc >= w_eff;
    // input index row*w + col has reached w + 1
    assign pos_ok = (in_row_reg >= IMG_H_W'(2))
                 || ((in_row_reg == IMG_H_W'(1)) && (in_col_reg != '0))
                 || ((in_row_reg == '0) && (j_ext >= w_eff + CW'(1)));

    assign emit = (do_pix && pos_ok && (out_row_reg < h_eff)) || do_flush;

    assign r_inc   = {1'b0, out_row_reg} + (IMG_H_W+1)'(1);
    assign c_inc   = CW'(out_col_reg) + CW'(1);
    assign r_last  = r_inc >= {1'b0, h_eff};
    assign c_last  = c_inc >= w_eff;
    assign border  = (out_row_reg == '0) || r_last || (out_col_reg == '0) || c_last;
    assign restart = emit && r_last && c_last;

    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;
    assign rd_addr  = in_col_reg;
    assign row_base = restart ? '0 : in_row_reg;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept)
        begin
            if (emit)
            begin
                if (restart)
                begin
                    out_col_next = '0;
                    out_row_next = '0;
                    in_col_next  = '0;
                    in_row_next  = '0;
                end
                else if (c_last)
                begin
                    out_col_next = '0;
                    out_row_next = r_inc[IMG_H_W-1:0];
                end
                else
                begin
                    out_col_next = c_inc[AW-1:0];
                end
            end
            if (do_pix)
            begin
                if (col_wrap)
                begin
                    in_col_next = '0;
                    in_row_next = row_base + IMG_H_W'(1);
                end
                else
                begin
                    in_col_next = j_inc[AW-1:0];
                    in_row_next = row_base;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (accept)
            begin
                s1_valid_reg      <= 1'b1;
                s1_ctl_reg.wr     <= do_pix;
                s1_ctl_reg.emit   <= emit;
                s1_ctl_reg.border <= border;
                s1_ctl_reg.last   <= r_last && c_last;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= in_col_reg;
            s1_pixel_reg <= in_pixel;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_pixel = s1_pixel_reg;

endmodule

`default_nettype wire

// ----- hdl/bipr_line_mem.sv -----
// Line memory holding the two previous rows, one entry per column: {upper, middle}.
// Read-before-write with forwarding of the write that retires as the next read issues.
// Depends on bipr_pkg.
`default_nettype none

module bipr_line_mem
    import bipr_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  wire logic [PIX_W-1:0]             wr_pixel,
    output logic      [PIX_W-1:0]             top,
    output logic      [PIX_W-1:0]             mid
);

    localparam int DW = 2 * PIX_W;

    logic [DW-1:0] row_mem [MAX_WIDTH];
    logic [DW-1:0] rdata_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_hit_reg;
    logic [DW-1:0] cur;
    logic [DW-1:0] wr_data;

    assign cur     = fwd_hit_reg ? fwd_data_reg : rdata_reg;
    assign top     = cur[DW-1:PIX_W];
    assign mid     = cur[PIX_W-1:0];
    // the middle row moves up, the new pixel becomes the middle row
    assign wr_data = {mid, wr_pixel};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            row_mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rdata_reg    <= row_mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else if (rd_en)
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
    end

endmodule

`default_nettype wire

// ----- hdl/bipr_window.sv -----
// Window stage: 3x3 zero flags, centre pixel, output value and output register.
// Depends on bipr_pkg.
`default_nettype none

module bipr_window
    import bipr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s1_valid,
    input  wire bipr_ctl_t        s1_ctl,
    input  wire logic [PIX_W-1:0] s1_pixel,
    input  wire logic [PIX_W-1:0] top,
    input  wire logic [PIX_W-1:0] mid,
    output logic                  s1_fire,
    output logic                  out_free,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic      [PIX_W-1:0] out_pixel,
    output logic                  out_last
);

    logic [8:0]       flags_reg;
    logic [PIX_W-1:0] centre_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             out_last_reg;
    logic [2:0]       col_flags;
    logic [8:0]       flags_shift, flags_use;
    logic [PIX_W-1:0] value;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid && (!s1_ctl.emit || out_free);

    assign col_flags   = {top == '0, mid == '0, s1_pixel == '0};
    assign flags_shift = {flags_reg[5:0], col_flags};
    assign flags_use   = s1_ctl.wr ? flags_shift : flags_reg;
    assign value       = (s1_ctl.border || (flags_use == WINDOW_ALL)) ? PIX_WHITE : centre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            centre_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                if (s1_ctl.emit && s1_ctl.last)
                begin
                    // frame done: window restarts, a pixel still leaves its middle value
                    flags_reg  <= '0;
                    centre_reg <= s1_ctl.wr ? mid : '0;
                end
                else if (s1_ctl.wr)
                begin
                    flags_reg  <= flags_shift;
                    centre_reg <= mid;
                end
            end
            if (s1_fire && s1_ctl.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_ctl.emit)
        begin
            out_pixel_reg <= value;
            out_last_reg  <= s1_ctl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ----- dv/bipr_board_pkg.sv -----
// Scoreboard for the 3x3 boundary extraction block: line stores, window and position
// tracking that predict every output pixel, and the queue of pixels still awaited.
// Depends on bipr_pkg.
`timescale 1ns / 1ps

package bipr_board_pkg;

    import bipr_pkg::*;

    localparam int LINE_DEPTH = 1024;

    typedef struct packed
    {
        logic [PIX_W-1:0] value;
        logic             last;
    } boundary_px_t;

    class boundary_board;
        logic [IMG_W_W-1:0] width_reg;
        logic [IMG_H_W-1:0] height_reg;
        logic [PIX_W-1:0]   upper_row [LINE_DEPTH];
        logic [PIX_W-1:0]   middle_row [LINE_DEPTH];
        logic [8:0]         zero_window;
        logic [PIX_W-1:0]   centre;
        int unsigned        in_col;
        int unsigned        in_row;
        int unsigned        out_col;
        int unsigned        out_row;
        boundary_px_t       awaited [$];
        int unsigned        failures;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            restart();
            failures = 0;
        endfunction

        function void restart();
            zero_window = '0;
            centre      = '0;
            in_col      = 0;
            in_row      = 0;
            out_col     = 0;
            out_row     = 0;
        endfunction

        function int unsigned cols();
            if (width_reg == 0)
                return 1;
            if (width_reg > LINE_DEPTH)
                return LINE_DEPTH;
            return width_reg;
        endfunction

        function int unsigned rows();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function void write_reg(reg_idx_t r, logic [31:0] v);
            if (r == REG_IMAGE_WIDTH)
                width_reg = v[IMG_W_W-1:0];
            else
                height_reg = v[IMG_H_W-1:0];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        // output at the current output position, taken from the current window
        function void push_output(int unsigned w, int unsigned h);
            bit           on_border;
            boundary_px_t px;
            on_border = (out_row == 0) || (out_row + 1 >= h) || (out_col == 0) ||
                        (out_col + 1 >= w);
            px.value  = (on_border || zero_window == WINDOW_ALL) ? PIX_WHITE : centre;
            px.last   = (out_row + 1 >= h) && (out_col + 1 >= w);
            awaited.push_back(px);
            if (px.last)
            begin
                restart();
            end
            else
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        // called for every accepted input transfer
        function void note_item(logic flush, logic [PIX_W-1:0] pix);
            int unsigned       w;
            int unsigned       h;
            int unsigned       j;
            logic [PIX_W-1:0]  top;
            logic [PIX_W-1:0]  mid;
            longint unsigned   pos;
            w = cols();
            h = rows();
            // flushes before the frame is complete and pixels after it are dropped
            if (flush)
            begin
                if (in_row >= h)
                    push_output(w, h);
                return;
            end
            if (in_row >= h)
                return;
            j = in_col;
            top = upper_row[j];
            mid = middle_row[j];
            upper_row[j]  = mid;
            middle_row[j] = pix;
            zero_window = {zero_window[5:0], top == 0, mid == 0, pix == 0};
            pos = longint'(in_row) * w + j;
            if (pos >= w + 1 && out_row < h)
                push_output(w, h);
            centre = mid;
            // column advances from the column just taken, even after a frame restart
            in_col = j + 1;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        endfunction

        function void check_pixel(logic [PIX_W-1:0] pix, logic last);
            boundary_px_t want;
            if (awaited.size() == 0)
            begin
                flag($sformatf("output pixel %0d last %0b with nothing awaited", pix, last));
                return;
            end
            want = awaited.pop_front();
            if (pix !== want.value)
                flag($sformatf("pixel_out expected %0d got %0d", want.value, pix));
            if (last !== want.last)
                flag($sformatf("frame_last expected %0b got %0b", want.last, last));
        endfunction
    endclass

endpackage

// ----- dv/binary_interior_point_removal_3x3_top_tb.sv -----
// Testbench top for the 3x3 boundary extraction block: APB setup, frame stimulus with
// random idling and backpressure, output checking against the scoreboard.
// Depends on bipr_pkg, bipr_if, bipr_board_pkg and the block's RTL.
`timescale 1ns / 1ps

module binary_interior_point_removal_3x3_top_tb;

    import bipr_pkg::*;
    import bipr_board_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bipr_in_if  pix_in ();
    bipr_out_if pix_out ();

    boundary_board board;
    bit            steady;
    bit            hold_req;
    int unsigned   cycles;
    int unsigned   random_items;

    logic [7:0] directed_px [15] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
                                     8'd0, 8'd0, 8'd0, 8'd1, 8'd0,
                                     8'd0, 8'd0, 8'd0, 8'd0, 8'd128};

    binary_interior_point_removal_3x3_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .item_in  (pix_in),
        .item_out (pix_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : drain
        int unsigned hold_left;
        hold_left = 0;
        pix_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pix_out.valid && pix_out.ready)
                board.check_pixel(pix_out.pixel_out, pix_out.frame_last);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end
            else
            begin
                pix_out.ready <= steady || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    task automatic send_item(logic flush, logic [7:0] pix);
        while (!steady && $urandom_range(0, 99) < 8)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.action   <= flush;
        pix_in.pixel_in <= pix;
        do
            @(posedge clk);
        while (!pix_in.ready);
        board.note_item(flush, pix);
    endtask

    task automatic stop_sending();
        pix_in.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_cycle(logic wr, reg_idx_t r, logic [31:0] v, output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(reg_idx_t r, logic [31:0] want);
        logic [31:0] got;
        apb_cycle(1'b0, r, '0, got);
        if (r == REG_IMAGE_WIDTH ? got[IMG_W_W-1:0] !== want[IMG_W_W-1:0]
                                 : got[IMG_H_W-1:0] !== want[IMG_H_W-1:0])
            board.flag($sformatf("register %s read %0d, written %0d", r.name(), got, want));
    endtask

    // registers change only once the block has drained
    task automatic configure(int unsigned w, int unsigned h);
        logic [31:0] unused;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        apb_cycle(1'b1, REG_IMAGE_WIDTH, w, unused);
        board.write_reg(REG_IMAGE_WIDTH, w);
        apb_cycle(1'b1, REG_IMAGE_HEIGHT, h, unused);
        board.write_reg(REG_IMAGE_HEIGHT, h);
        check_reg(REG_IMAGE_WIDTH, w);
        check_reg(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic run_frame(int unsigned w, int unsigned h, int unsigned zero_pct,
                             int unsigned noise_pct, bit squeeze);
        int unsigned we;
        int unsigned he;
        configure(w, h);
        if (squeeze)
            hold_req = 1'b1;
        we = board.cols();
        he = board.rows();
        for (int unsigned k = 0; k < we * he; k++)
        begin
            // flush before the frame is complete, dropped by the block
            if ($urandom_range(0, 99) < noise_pct)
                send_item(1'b1, 8'($urandom));
            send_item(1'b0, ($urandom_range(0, 99) < zero_pct) ? 8'd0 : 8'($urandom));
            random_items++;
        end
        for (int unsigned k = 0; k <= we; k++)
        begin
            // stray pixel between frame end and the last flush, dropped
            if ($urandom_range(0, 99) < noise_pct)
                send_item(1'b0, 8'($urandom));
            send_item(1'b1, 8'($urandom));
            random_items++;
        end
        stop_sending();
    endtask

    initial
    begin : stimulus
        int unsigned frame_no;
        int unsigned w;
        int unsigned h;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pix_in.valid    = 1'b0;
        pix_in.action   = 1'b0;
        pix_in.pixel_in = '0;
        steady          = 1'b0;
        hold_req        = 1'b0;
        random_items    = 0;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reg(REG_IMAGE_WIDTH, WIDTH_RESET);
        check_reg(REG_IMAGE_HEIGHT, HEIGHT_RESET);

        // 5x3 frame: one all-zero window, two touched by a 1, corner values 255 and 128
        configure(5, 3);
        send_item(1'b1, 8'h00);
        foreach (directed_px[i])
            send_item(1'b0, directed_px[i]);
        send_item(1'b0, 8'hFF);
        repeat (6) send_item(1'b1, 8'hA5);
        stop_sending();

        // output held off long enough that the block backs up into the input
        run_frame(6, 40, 50, 0, 1'b1);

        random_items = 0;
        frame_no = 0;
        while (random_items < 860)
        begin
            steady = (frame_no >= 4 && frame_no < 8);
            case ($urandom_range(0, 19))
                0:       w = 0;
                1, 2, 3: w = $urandom_range(13, 48);
                default: w = $urandom_range(1, 12);
            endcase
            h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
            run_frame(w, h, $urandom_range(30, 90), $urandom_range(0, 4), 1'b0);
            frame_no++;
        end
        steady = 1'b0;

        // size extremes: zero registers clamp, a wide short frame, a single column, a 3x3 frame
        run_frame(0, 0, 50, 2, 1'b0);
        run_frame(48, 2, 80, 1, 1'b0);
        run_frame(1, 60, 50, 0, 1'b0);
        run_frame(3, 3, 90, 2, 1'b0);

        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bipr_pkg.sv
hdl/bipr_if.sv
hdl/bipr_cfg.sv
hdl/bipr_ctrl.sv
hdl/bipr_line_mem.sv
hdl/bipr_window.sv
hdl/binary_interior_point_removal_3x3_top.sv
dv/bipr_board_pkg.sv
dv/binary_interior_point_removal_3x3_top_tb.sv
